// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the RTL files that carry checks.
// Each macro takes a label, a clock, an active high reset, the condition(s) and a message.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// A condition that implies another one at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that implies another one at the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pfe_pkg.sv -----
// ---------------------------------------------------------------------------
// pfe_pkg
// Types and constants of the postfix expression evaluator.
// ---------------------------------------------------------------------------
package pfe_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int CHAR_WIDTH   = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int STEP_WIDTH   = $clog2(DATA_WIDTH);

   // Last step index of a bit-serial multiply or divide.
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DATA_WIDTH - 1);

   // Operator characters and the operand bias.
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK,
      ST_OVERFLOW,
      ST_UNDERFLOW,
      ST_DIVZERO
   } status_type;

   // Command from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_ctl_type;

   // Completion from the arithmetic unit.
   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] result;
   } alu_res_type;

endpackage

// ----- rtl/core/pfe_req_if.sv -----
// ---------------------------------------------------------------------------
// pfe_req_if
// Input channel: one expression character per word, with a final flag.
// ---------------------------------------------------------------------------
interface pfe_req_if;

   logic                             valid;
   logic                             ready;
   logic [pfe_pkg::CHAR_WIDTH-1:0]   char_code;
   logic                             last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);

endinterface

// ----- rtl/core/pfe_rsp_if.sv -----
// ---------------------------------------------------------------------------
// pfe_rsp_if
// Result channel: evaluated value and status of one expression.
// ---------------------------------------------------------------------------
interface pfe_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [pfe_pkg::DATA_WIDTH-1:0] value;
   logic [pfe_pkg::STATUS_WIDTH-1:0]    status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);

endinterface

// ----- rtl/core/pfe_ram.sv -----
// ---------------------------------------------------------------------------
// pfe_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pfe_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pfe_alu.sv -----
// ---------------------------------------------------------------------------
// pfe_alu
// Shared arithmetic unit: one 33-bit adder reused for add, subtract,
// shift-add multiply and restoring divide, one bit per cycle.
// ---------------------------------------------------------------------------
module pfe_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pfe_pkg::alu_ctl_type                 ctl,
   input  logic [pfe_pkg::DATA_WIDTH-1:0]       lhs,
   input  logic [pfe_pkg::DATA_WIDTH-1:0]       rhs,
   output pfe_pkg::alu_res_type                 res
);

   localparam int DW = pfe_pkg::DATA_WIDTH;

   typedef enum logic [2:0] {
      A_IDLE,
      A_ARITH,
      A_MUL,
      A_NEGA,
      A_NEGB,
      A_DIV,
      A_NEGQ
   } alu_state_type;

   alu_state_type                        state_ff, state_in;
   pfe_pkg::op_type                      op_ff, op_in;
   logic [DW-1:0]                        x_ff, x_in;
   logic [DW-1:0]                        y_ff, y_in;
   logic [DW-1:0]                        acc_ff, acc_in;
   logic [pfe_pkg::STEP_WIDTH-1:0]       step_ff, step_in;
   logic                                 neg_ff, neg_in;
   logic                                 done_ff, done_in;
   logic [DW-1:0]                        result_ff, result_in;

   logic [DW:0] add_a;
   logic [DW:0] add_b;
   logic        add_sub;
   logic [DW:0] sum;

   // The one shared adder; subtraction inverts b and carries in one.
   assign sum = add_a + (add_b ^ {(DW + 1){add_sub}}) + (DW + 1)'(add_sub);

   // Operand selection for the adder.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         A_ARITH: begin
            add_a   = {1'b0, x_ff};
            add_b   = {1'b0, y_ff};
            add_sub = (op_ff == pfe_pkg::OP_SUB);
         end
         A_MUL: begin
            add_a = {1'b0, acc_ff};
            add_b = {1'b0, x_ff};
         end
         A_NEGA: begin
            add_b   = {1'b0, x_ff};
            add_sub = 1'b1;
         end
         A_NEGB: begin
            add_b   = {1'b0, y_ff};
            add_sub = 1'b1;
         end
         A_DIV: begin
            add_a   = {acc_ff, x_ff[DW-1]};
            add_b   = {1'b0, y_ff};
            add_sub = 1'b1;
         end
         A_NEGQ: begin
            add_b   = {1'b0, x_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // Sequencer over the shared adder.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in   = ctl.op;
               x_in    = lhs;
               y_in    = rhs;
               acc_in  = '0;
               step_in = '0;
               unique case (ctl.op)
                  pfe_pkg::OP_MUL: state_in = A_MUL;
                  pfe_pkg::OP_DIV: state_in = A_NEGA;
                  default:         state_in = A_ARITH;
               endcase
            end
         end
         A_ARITH: begin
            result_in = sum[DW-1:0];
            done_in   = 1'b1;
            state_in  = A_IDLE;
         end
         A_MUL: begin
            // Add the shifted multiplicand where the multiplier bit is set.
            if (y_ff[0]) begin
               acc_in = sum[DW-1:0];
            end
            x_in    = {x_ff[DW-2:0], 1'b0};
            y_in    = {1'b0, y_ff[DW-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == pfe_pkg::LAST_STEP) begin
               result_in = acc_in;
               done_in   = 1'b1;
               state_in  = A_IDLE;
            end
         end
         A_NEGA: begin
            // Magnitude of the dividend and sign of the quotient.
            neg_in = x_ff[DW-1] ^ y_ff[DW-1];
            if (x_ff[DW-1]) begin
               x_in = sum[DW-1:0];
            end
            state_in = A_NEGB;
         end
         A_NEGB: begin
            if (y_ff[DW-1]) begin
               y_in = sum[DW-1:0];
            end
            state_in = A_DIV;
         end
         A_DIV: begin
            // Restoring step: keep the difference when it did not borrow.
            if (!sum[DW]) begin
               acc_in = sum[DW-1:0];
               x_in   = {x_ff[DW-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[DW-2:0], x_ff[DW-1]};
               x_in   = {x_ff[DW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == pfe_pkg::LAST_STEP) begin
               state_in = A_NEGQ;
            end
         end
         A_NEGQ: begin
            result_in = neg_ff ? sum[DW-1:0] : x_ff;
            done_in   = 1'b1;
            state_in  = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign res.done   = done_ff;
   assign res.result = result_ff;

endmodule

// ----- rtl/core/postfix_expression_evaluator_top.sv -----
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Evaluates a postfix expression fed one character per word and returns the
// value of the expression with a status code on the final character.
// ---------------------------------------------------------------------------
// Each input word carries one character; any byte other than + - * / pushes
// (byte - 48). The top of stack is held in a register, the left operand of
// an operator comes from the stack RAM by a registered read, and the shared
// arithmetic unit works one bit per cycle over 32 bits for multiply and
// divide, with two sign steps before and one after a divide. The final word
// hands the result to the output register once it is empty or being taken;
// that register lets the next expression start while the result waits. The
// first error (overflow, underflow, divide by zero) is reported in the
// status, and the stack and the error are cleared after each result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   pfe_req_if.sink      req_ch,
   pfe_rsp_if.source    rsp_ch
);

   localparam int DW = pfe_pkg::DATA_WIDTH;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CALC,
      S_FINISH
   } seq_state_type;

   seq_state_type            state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   pfe_pkg::status_type      err_ff, err_in;
   logic [DW-1:0]            tos_ff, tos_in;
   pfe_pkg::op_type          op_ff, op_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]            rsp_value_ff, rsp_value_in;
   pfe_pkg::status_type      rsp_status_ff, rsp_status_in;

   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic                     ram_rd_en;
   logic [AW-1:0]            ram_rd_addr;
   logic [DW-1:0]            ram_rd_data;

   pfe_pkg::alu_ctl_type     alu_ctl;
   pfe_pkg::alu_res_type     alu_res;

   logic                     req_fire;
   logic                     is_op;
   pfe_pkg::op_type          char_op;
   logic [DW-1:0]            digit_word;
   logic [CW-1:0]            count_m1;
   logic [CW-1:0]            count_m2;

   // Keep the first error only.
   function automatic pfe_pkg::status_type merge_error(
      pfe_pkg::status_type cur,
      pfe_pkg::status_type code
   );
      return (cur == pfe_pkg::ST_OK) ? code : cur;
   endfunction

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign digit_word   = DW'(req_ch.char_code) - DW'(pfe_pkg::CHAR_ZERO);
   assign count_m1     = count_ff - CW'(1);
   assign count_m2     = count_ff - CW'(2);

   // Character decode.
   always_comb begin
      is_op   = 1'b1;
      char_op = pfe_pkg::OP_ADD;
      unique case (req_ch.char_code)
         pfe_pkg::CHAR_PLUS:  char_op = pfe_pkg::OP_ADD;
         pfe_pkg::CHAR_MINUS: char_op = pfe_pkg::OP_SUB;
         pfe_pkg::CHAR_STAR:  char_op = pfe_pkg::OP_MUL;
         pfe_pkg::CHAR_SLASH: char_op = pfe_pkg::OP_DIV;
         default:             is_op   = 1'b0;
      endcase
   end

   // Sequencer: push, operator fetch and compute, and result hand-off.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_m1[AW-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = count_m2[AW-1:0];
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               last_in  = req_ch.last_char;
               op_in    = char_op;
               state_in = req_ch.last_char ? S_FINISH : S_IDLE;
               if (is_op) begin
                  if (count_ff < CW'(2)) begin
                     err_in = merge_error(err_ff, pfe_pkg::ST_UNDERFLOW);
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = S_FETCH;
                  end
               end else if (count_ff == CW'(STACK_DEPTH)) begin
                  err_in = merge_error(err_ff, pfe_pkg::ST_OVERFLOW);
               end else begin
                  // Old top goes down into the RAM.
                  ram_wr_en = (count_ff != '0);
                  tos_in    = digit_word;
                  count_in  = count_ff + CW'(1);
               end
            end
         end
         S_FETCH: begin
            // Left operand is now on the RAM read port.
            if ((op_ff == pfe_pkg::OP_DIV) && (tos_ff == '0)) begin
               err_in   = merge_error(err_ff, pfe_pkg::ST_DIVZERO);
               tos_in   = '0;
               count_in = count_m1;
               state_in = last_ff ? S_FINISH : S_IDLE;
            end else begin
               alu_ctl.start = 1'b1;
               state_in      = S_CALC;
            end
         end
         S_CALC: begin
            if (alu_res.done) begin
               tos_in   = alu_res.result;
               count_in = count_m1;
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = merge_error(err_ff, pfe_pkg::ST_UNDERFLOW);
               end else begin
                  rsp_value_in  = tos_ff;
                  rsp_status_in = err_ff;
               end
               count_in = '0;
               err_in   = pfe_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= pfe_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff        <= tos_in;
      op_ff         <= op_in;
      last_ff       <= last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

   // Stack entries below the top.
   pfe_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (tos_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared arithmetic unit: left operand from the RAM, right from the top.
   pfe_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .lhs   (ram_rd_data),
      .rhs   (tos_ff),
      .res   (alu_res)
   );

   // Checks on the sequencer.
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(STACK_DEPTH), "stack count beyond depth")
   `ASSERT_IMPLY(a_done_in_calc, clock, reset, alu_res.done, state_ff == S_CALC, "unit done outside compute")
   `ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH, "result raised outside finish")
   `ASSERT_NEXT(a_push_count, clock, reset, req_fire && !is_op && !req_ch.last_char && (count_ff < CW'(STACK_DEPTH)), count_ff == $past(count_ff) + CW'(1), "push did not grow the stack")

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives postfix expressions into postfix_expression_evaluator_top, one
// character per word, and checks each value and status returned against an
// expression evaluator kept inside the bench. Directed tests cover every
// operator, the byte extremes, the stack error cases and a long back-pressure
// stretch. Random expressions, mostly well formed, then run under several
// idling mixes.
// ---------------------------------------------------------------------------
module testbench;

   localparam int STACK_DEPTH = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_GAP = 60;
   localparam int MAX_REPORTS = 10;
   localparam int DW = pfe_pkg::DATA_WIDTH;
   localparam int CW = pfe_pkg::CHAR_WIDTH;

   typedef struct {
      logic signed [DW-1:0]  value;
      pfe_pkg::status_type   status;
   } expr_result_type;

   logic clock;
   logic reset;

   pfe_req_if req_bus ();
   pfe_rsp_if rsp_bus ();

   postfix_expression_evaluator_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   // Evaluator state mirrored by the bench.
   logic [DW-1:0]         operand_stack [STACK_DEPTH];
   int                    stack_depth = 0;
   pfe_pkg::status_type   eval_error = pfe_pkg::ST_OK;
   expr_result_type       pending_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoff_request = 0;
   int words_sent = 0;
   int mismatch_count = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   initial begin
      int cycle_count;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   function automatic logic is_operator(input logic [CW-1:0] code);
      return code == pfe_pkg::CHAR_PLUS || code == pfe_pkg::CHAR_MINUS ||
             code == pfe_pkg::CHAR_STAR || code == pfe_pkg::CHAR_SLASH;
   endfunction

   function automatic void note_fault(input pfe_pkg::status_type code);
      if (eval_error == pfe_pkg::ST_OK) eval_error = code;
   endfunction

   function automatic void push_operand(input logic [DW-1:0] operand);
      if (stack_depth >= STACK_DEPTH) begin
         note_fault(pfe_pkg::ST_OVERFLOW);
      end else begin
         operand_stack[stack_depth] = operand;
         stack_depth++;
      end
   endfunction

   // Signed division on raw bit patterns, truncating toward zero; the most
   // negative value divided by -1 wraps back to itself.
   function automatic logic [DW-1:0] trunc_quotient(
      input logic [DW-1:0] dividend,
      input logic [DW-1:0] divisor
   );
      logic [DW-1:0] mag_a;
      logic [DW-1:0] mag_b;
      logic [DW-1:0] quot;
      mag_a = dividend[DW-1] ? -dividend : dividend;
      mag_b = divisor[DW-1] ? -divisor : divisor;
      quot = mag_a / mag_b;
      return (dividend[DW-1] != divisor[DW-1]) ? -quot : quot;
   endfunction

   // Applies one accepted character to the mirrored stack and, on the final
   // character, queues the value and status the block must return.
   function automatic void evaluate_word(
      input logic [CW-1:0] code,
      input logic          final_flag
   );
      logic [DW-1:0]    right;
      logic [DW-1:0]    left;
      logic [DW-1:0]    outcome;
      expr_result_type  answer;
      if (is_operator(code)) begin
         if (stack_depth < 2) begin
            note_fault(pfe_pkg::ST_UNDERFLOW);
         end else begin
            right = operand_stack[stack_depth-1];
            left = operand_stack[stack_depth-2];
            stack_depth -= 2;
            case (code)
               pfe_pkg::CHAR_PLUS: outcome = left + right;
               pfe_pkg::CHAR_MINUS: outcome = left - right;
               pfe_pkg::CHAR_STAR: outcome = left * right;
               default: begin
                  if (right == '0) begin
                     note_fault(pfe_pkg::ST_DIVZERO);
                     outcome = '0;
                  end else begin
                     outcome = trunc_quotient(left, right);
                  end
               end
            endcase
            push_operand(outcome);
         end
      end else begin
         push_operand(DW'(code) - DW'(pfe_pkg::CHAR_ZERO));
      end
      if (final_flag) begin
         answer.value = '0;
         if (stack_depth == 0) note_fault(pfe_pkg::ST_UNDERFLOW);
         else answer.value = operand_stack[stack_depth-1];
         answer.status = eval_error;
         pending_results.push_back(answer);
         stack_depth = 0;
         eval_error = pfe_pkg::ST_OK;
      end
   endfunction

   // Offers one word after a random idle gap and waits for it to be taken.
   // The valid stays high on return so that the next word can follow at once.
   task automatic send_word(input logic [CW-1:0] code, input logic final_flag);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= code;
      req_bus.last_char <= final_flag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      evaluate_word(code, final_flag);
      words_sent++;
   endtask

   task automatic send_expression(input logic [CW-1:0] codes [$]);
      foreach (codes[k]) send_word(codes[k], k == codes.size() - 1);
   endtask

   // Drops the valid and waits until every queued result has come back.
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] pick_operator();
      case ($urandom_range(3))
         0: return pfe_pkg::CHAR_PLUS;
         1: return pfe_pkg::CHAR_MINUS;
         2: return pfe_pkg::CHAR_STAR;
         default: return pfe_pkg::CHAR_SLASH;
      endcase
   endfunction

   // Mostly decimal digits, otherwise any byte that is not an operator.
   function automatic logic [CW-1:0] pick_operand();
      logic [CW-1:0] code;
      if ($urandom_range(9) < 7) return pfe_pkg::CHAR_ZERO + CW'($urandom_range(9));
      do code = CW'($urandom); while (is_operator(code));
      return code;
   endfunction

   // A valid postfix expression with the given number of operands. The depth
   // is kept below the stack size so that no push is lost.
   task automatic send_wellformed_expr(input int operand_total);
      int            depth;
      int            pushed;
      logic [CW-1:0] code;
      depth = 0;
      pushed = 0;
      while (pushed < operand_total || depth > 1) begin
         if (depth >= 2 && (pushed >= operand_total || depth >= STACK_DEPTH - 1 ||
                            $urandom_range(1) == 1)) begin
            code = pick_operator();
            depth--;
         end else begin
            code = pick_operand();
            depth++;
            pushed++;
         end
         send_word(code, pushed >= operand_total && depth == 1);
      end
   endtask

   // Random bytes with no structure; long runs are mostly pushes so that
   // the stack overflows now and then.
   task automatic send_noise_expr();
      int            span;
      int            op_pct;
      logic [CW-1:0] code;
      if ($urandom_range(3) == 0) begin
         span = $urandom_range(STACK_DEPTH, STACK_DEPTH + 6);
         op_pct = 5;
      end else begin
         span = $urandom_range(1, 8);
         op_pct = 35;
      end
      for (int k = 0; k < span; k++) begin
         if ($urandom_range(99) < op_pct) code = pick_operator();
         else code = CW'($urandom);
         send_word(code, k == span - 1);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int word_total);
      int target;
      target = words_sent + word_total;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (words_sent < target) begin
         if ($urandom_range(4) == 0) send_noise_expr();
         else if ($urandom_range(9) == 0) send_wellformed_expr($urandom_range(7, 16));
         else send_wellformed_expr($urandom_range(1, 5));
      end
      wait_results_drained();
   endtask

   // Every operator, the byte extremes and a negative truncating divide.
   task automatic test_operators();
      logic [CW-1:0] codes [$];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      codes = '{8'hFF, 8'h00, pfe_pkg::CHAR_MINUS, 8'h39, pfe_pkg::CHAR_STAR, 8'h37,
                pfe_pkg::CHAR_PLUS, 8'h20, pfe_pkg::CHAR_SLASH};
      send_expression(codes);
   endtask

   // Builds the most negative value and divides it by -1.
   task automatic test_min_by_minus_one();
      logic [CW-1:0] codes [$];
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      codes = '{8'h20, 8'hB0, pfe_pkg::CHAR_STAR, 8'hB0, pfe_pkg::CHAR_STAR, 8'hB0,
                pfe_pkg::CHAR_STAR, 8'h70, pfe_pkg::CHAR_STAR, pfe_pkg::CHAR_ZERO, 8'h31,
                pfe_pkg::CHAR_MINUS, pfe_pkg::CHAR_SLASH};
      send_expression(codes);
   endtask

   // One push more than the stack holds; the last push is dropped.
   task automatic test_overflow();
      for (int k = 0; k <= STACK_DEPTH; k++) begin
         send_word(pfe_pkg::CHAR_ZERO + CW'(k), k == STACK_DEPTH);
      end
   endtask

   // Operator on a single entry, then an operator on an empty stack at the end.
   task automatic test_underflow();
      logic [CW-1:0] codes [$];
      codes = '{8'h35, pfe_pkg::CHAR_PLUS};
      send_expression(codes);
      codes = '{pfe_pkg::CHAR_PLUS};
      send_expression(codes);
   endtask

   task automatic test_divide_by_zero();
      logic [CW-1:0] codes [$];
      codes = '{8'h37, pfe_pkg::CHAR_ZERO, pfe_pkg::CHAR_SLASH};
      send_expression(codes);
      wait_results_drained();
   endtask

   // The receiver holds off while words keep coming, so the block fills up
   // and stalls its input; then the sender waits for every result.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_request = 400;
      repeat (10) send_wellformed_expr($urandom_range(1, 3));
      wait_results_drained();
   endtask

   // Result ready, with random stalls and an occasional long hold-off.
   initial begin
      int holdoff_left;
      holdoff_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request > 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compares each returned word with the oldest queued result.
   always @(posedge clock) begin
      expr_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result: value %0d status %0d",
                        rsp_bus.value, rsp_bus.status);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.value !== want.value || rsp_bus.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: value %0d status %0d, expected value %0d status %0d",
                           rsp_bus.value, rsp_bus.status, want.value, want.status);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      req_bus.valid <= 1'b0;
      req_bus.char_code <= '0;
      req_bus.last_char <= 1'b0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_operators();
      test_min_by_minus_one();
      test_overflow();
      test_underflow();
      test_divide_by_zero();
      test_backpressure();
      run_random_phase(0, 0, 165);
      run_random_phase(88, 0, 165);
      run_random_phase(0, 88, 165);
      run_random_phase(37, 37, 165);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
